// ----- hw/rtl/dckf_pkg.sv -----
// ----------------------------------------------------------------------------
// dckf_pkg
// Shared types, lighting keyframe tables and constants for the day-cycle
// keyframe interpolator.
// ----------------------------------------------------------------------------
package dckf_pkg;

	// keyframe table geometry
	localparam int KF_COUNT = 8;
	localparam int KF_IDX_W = $clog2(KF_COUNT);
	localparam int CHANNELS = 7;
	localparam int CH_W     = $clog2(CHANNELS + 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_SCALE = 2'd0,
		REG_START_HOUR = 2'd1
	} reg_idx_t;

	localparam logic [15:0] TIME_SCALE_RST = 16'd256;
	localparam logic [15:0] START_HOUR_RST = 16'd0;

	// fixed-point constants
	localparam logic [15:0] DAY_Q11     = 16'd49152;     // 24 h in Q5.11
	localparam logic [28:0] MIN_WRAP    = 29'd94371840;  // 1440 min in Q.16
	localparam logic [20:0] DIV15_RECIP = 21'd1118482;   // ceil(2^24 / 15)
	localparam logic [16:0] MIN_SPAN    = 17'd20;        // 0.01 h in Q5.11
	localparam logic [16:0] T_ONE       = 17'd65536;     // 1.0 in Q0.16

	// shared multiplier
	localparam int MUL_W  = 22;
	localparam int PROD_W = 2 * MUL_W;

	// keyframe hours, Q5.11, ascending
	localparam logic [15:0] KF_HOUR [KF_COUNT] = '{
		16'd0, 16'd10240, 16'd13312, 16'd16384,
		16'd24576, 16'd32768, 16'd37888, 16'd40960
	};

	// altitude, azimuth, intensity, red, green, blue, sky
	localparam logic signed [16:0] KF_CHAN [KF_COUNT][CHANNELS] = '{
		'{-17'sd6554,  17'sd25723, 17'sd0,    17'sd3277,  17'sd3277,  17'sd6554,  17'sd4096},
		'{-17'sd1638, -17'sd19333, 17'sd819,  17'sd26214, 17'sd13107, 17'sd6554,  17'sd8192},
		'{ 17'sd1229, -17'sd15401, 17'sd4915, 17'sd32768, 17'sd22938, 17'sd13107, 17'sd20480},
		'{ 17'sd4096, -17'sd11715, 17'sd7373, 17'sd32768, 17'sd31130, 17'sd27853, 17'sd32768},
		'{ 17'sd9830,  17'sd0,     17'sd9011, 17'sd32768, 17'sd32113, 17'sd31130, 17'sd40960},
		'{ 17'sd4915,  17'sd11715, 17'sd7782, 17'sd32768, 17'sd31130, 17'sd27853, 17'sd32768},
		'{ 17'sd819,   17'sd16712, 17'sd4096, 17'sd32768, 17'sd19661, 17'sd9830,  17'sd16384},
		'{-17'sd2458,  17'sd20562, 17'sd410,  17'sd9830,  17'sd6554,  17'sd9830,  17'sd6554}
	};

	// round(2^32 / span) for the segment starting at each keyframe
	localparam logic [20:0] KF_RECIP [KF_COUNT] = '{
		21'd419430, 21'd1398101, 21'd1398101, 21'd524288,
		21'd524288, 21'd838861, 21'd1398101, 21'd524288
	};

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_HOUR,
		ST_SEG,
		ST_FRAC,
		ST_TCLAMP,
		ST_CHAN,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic [15:0] time_scale;
		logic [15:0] start_hour;
	} cfg_t;

	typedef struct packed {
		logic        [15:0] hour_of_day;
		logic signed [15:0] sun_altitude;
		logic signed [15:0] sun_azimuth;
		logic        [15:0] sun_intensity;
		logic        [15:0] sun_red;
		logic        [15:0] sun_green;
		logic        [15:0] sun_blue;
		logic        [15:0] sky_intensity;
	} result_t;

	// next keyframe, wrapping past midnight
	function automatic logic [KF_IDX_W-1:0] kf_next(input logic [KF_IDX_W-1:0] i);
		return (i == KF_IDX_W'(KF_COUNT - 1)) ? '0 : i + 1'b1;
	endfunction

	// segment too short to interpolate
	function automatic logic kf_short(input logic [KF_IDX_W-1:0] ia);
		logic [16:0] span;
		span = {1'b0, KF_HOUR[kf_next(ia)]} - {1'b0, KF_HOUR[ia]};
		if (KF_HOUR[kf_next(ia)] <= KF_HOUR[ia])
			span = span + {1'b0, DAY_Q11};
		return span <= MIN_SPAN;
	endfunction

	// channel step across the segment starting at ia
	function automatic logic signed [17:0] kf_delta(input logic [KF_IDX_W-1:0] ia,
			input logic [CH_W-1:0] ch);
		return 18'(KF_CHAN[kf_next(ia)][ch]) - 18'(KF_CHAN[ia][ch]);
	endfunction

endpackage

// ----- hw/rtl/dckf_front.sv -----
// ----------------------------------------------------------------------------
// dckf_front
// Input side: takes tick items and holds them in a short queue until the
// sequencer is free.
// ----------------------------------------------------------------------------
module dckf_front #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [19:0] elapsed_seconds,
	input  logic        take,
	output logic        avail,
	output logic [19:0] head_secs
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [19:0]      slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_take;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign avail     = (count_q != '0);
	assign do_push   = push && !full;
	assign do_take   = take && avail;
	assign head_secs = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= elapsed_seconds;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_take)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_take)
				count_q <= count_q + 1'b1;
			else if (do_take && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- hw/rtl/dckf_engine.sv -----
// ----------------------------------------------------------------------------
// dckf_engine
// Sequencer around one shared multiplier: advances the game clock, forms the
// hour of day, finds the keyframe segment and interpolates the seven channels.
// ----------------------------------------------------------------------------
module dckf_engine
	import dckf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        avail,
	input  logic [19:0] head_secs,
	output logic        take,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res
);

	eng_state_t state_q, state_nx;

	logic        [26:0]         gm_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic        [15:0]         hour_q;
	logic        [KF_IDX_W-1:0] ia_q;
	logic        [15:0]         d_q;
	logic                       short_q;
	logic        [16:0]         t_q;
	logic        [CH_W-1:0]     ch_q;
	logic        [15:0]         res_q [CHANNELS];

	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic        [CH_W-1:0]     ch_mul;
	logic        [CH_W-1:0]     ch_rd;
	logic        [28:0]         gm_sum;
	logic        [28:0]         gm_next;
	logic        [16:0]         hr_sum;
	logic        [16:0]         hr_next;
	logic                       seg_found;
	logic        [KF_IDX_W-1:0] seg_ib;
	logic        [KF_IDX_W-1:0] seg_ia;
	logic        [15:0]         seg_d;
	logic        [21:0]         frac;
	logic signed [PROD_W-1:0]   rnd;
	logic        [15:0]         chan_val;

	// channel being multiplied and channel being rounded
	assign ch_mul = (ch_q == CH_W'(CHANNELS)) ? '0 : ch_q;
	assign ch_rd  = (ch_q == '0) ? '0 : ch_q - 1'b1;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (avail) state_nx = ST_ACC;
			ST_ACC:    state_nx = ST_DIV;
			ST_DIV:    state_nx = ST_HOUR;
			ST_HOUR:   state_nx = ST_SEG;
			ST_SEG:    state_nx = ST_FRAC;
			ST_FRAC:   state_nx = ST_TCLAMP;
			ST_TCLAMP: state_nx = ST_CHAN;
			ST_CHAN:   if (ch_q == CH_W'(CHANNELS)) state_nx = ST_DONE;
			ST_DONE:   if (res_ready) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		take      = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: take      = avail;
			ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: begin
				mul_a = {2'b00, head_secs};
				mul_b = {6'd0, cfg.time_scale};
			end
			ST_DIV: begin
				mul_a = {2'b00, gm_q[26:7]};
				mul_b = {1'b0, DIV15_RECIP};
			end
			ST_FRAC: begin
				mul_a = {6'd0, d_q};
				mul_b = {1'b0, KF_RECIP[ia_q]};
			end
			ST_CHAN: begin
				mul_a = MUL_W'(kf_delta(ia_q, ch_mul));
				mul_b = {5'd0, t_q};
			end
			default: ;
		endcase
	end

	// accumulator wrap at 1440 minutes: the sum stays below four wraps
	always_comb begin
		gm_sum = {2'b00, gm_q} + {1'b0, prod_q[35:8]};
		if (gm_sum >= 29'(3 * 94371840))
			gm_next = gm_sum - 29'(3 * 94371840);
		else if (gm_sum >= 29'(2 * 94371840))
			gm_next = gm_sum - 29'(2 * 94371840);
		else if (gm_sum >= MIN_WRAP)
			gm_next = gm_sum - MIN_WRAP;
		else
			gm_next = gm_sum;
	end

	// hour of day: start hour plus minutes / 60, wrap at 24 h
	always_comb begin
		hr_sum = {1'b0, cfg.start_hour} + {1'b0, prod_q[39:24]};
		if (hr_sum >= 17'(2 * 49152))
			hr_next = hr_sum - 17'(2 * 49152);
		else if (hr_sum >= {1'b0, DAY_Q11})
			hr_next = hr_sum - {1'b0, DAY_Q11};
		else
			hr_next = hr_sum;
	end

	// segment search: first keyframe later than the hour
	always_comb begin
		seg_found = 1'b0;
		seg_ib    = '0;
		for (int i = KF_COUNT - 1; i >= 0; i--) begin
			if (KF_HOUR[i] > hour_q) begin
				seg_found = 1'b1;
				seg_ib    = KF_IDX_W'(i);
			end
		end
		if (seg_found && seg_ib != '0)
			seg_ia = seg_ib - 1'b1;
		else
			seg_ia = KF_IDX_W'(KF_COUNT - 1);
		seg_d = hour_q - KF_HOUR[seg_ia];
		if (hour_q < KF_HOUR[seg_ia])
			seg_d = seg_d + DAY_Q11;
	end

	// fraction and rounding
	assign frac     = prod_q[37:16];
	assign rnd      = prod_q + PROD_W'(32768);
	assign chan_val = KF_CHAN[ia_q][ch_rd][15:0] + rnd[31:16];

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gm_q    <= '0;
			ch_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_ACC)
				gm_q <= gm_next[26:0];
			if (state_q == ST_TCLAMP)
				ch_q <= '0;
			else if (state_q == ST_CHAN)
				ch_q <= ch_q + 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_HOUR)
			hour_q <= hr_next[15:0];
		if (state_q == ST_SEG) begin
			ia_q    <= seg_ia;
			d_q     <= seg_d;
			short_q <= kf_short(seg_ia);
		end
		if (state_q == ST_TCLAMP) begin
			if (short_q)
				t_q <= '0;
			else if (frac > {5'd0, T_ONE})
				t_q <= T_ONE;
			else
				t_q <= frac[16:0];
		end
		// channel results shift in, altitude ends at the front
		if (state_q == ST_CHAN && ch_q != '0) begin
			for (int c = 0; c < CHANNELS - 1; c++)
				res_q[c] <= res_q[c + 1];
			res_q[CHANNELS - 1] <= chan_val;
		end
	end

	assign res.hour_of_day   = hour_q;
	assign res.sun_altitude  = res_q[0];
	assign res.sun_azimuth   = res_q[1];
	assign res.sun_intensity = res_q[2];
	assign res.sun_red       = res_q[3];
	assign res.sun_green     = res_q[4];
	assign res.sun_blue      = res_q[5];
	assign res.sky_intensity = res_q[6];

endmodule

// ----- hw/rtl/dckf_outq.sv -----
// ----------------------------------------------------------------------------
// dckf_outq
// Result side: one-entry holding register presented as a queue head.
// ----------------------------------------------------------------------------
module dckf_outq
	import dckf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load_valid,
	output logic    load_ready,
	input  result_t load_data,
	output logic    empty,
	input  logic    pop,
	output result_t head
);

	logic    valid_q;
	result_t data_q;

	assign empty      = !valid_q;
	assign load_ready = !valid_q || pop;
	assign head       = data_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load_valid && load_ready)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	// payload
	always_ff @(posedge clk) begin
		if (load_valid && load_ready)
			data_q <= load_data;
	end

endmodule

// ----- hw/rtl/day_cycle_keyframe_interpolator.sv -----
// ----------------------------------------------------------------------------
// day_cycle_keyframe_interpolator
// A result shows with empty low. Items pass through the sequencer one at a
// time: it takes the next item only after handing the last result on, since
// its single multiplier serves every step, the seven channel products included.
// Reset clears the minute accumulator and both queues; time_scale = 1.0,
// start_hour = 0.
// ----------------------------------------------------------------------------
module day_cycle_keyframe_interpolator
	import dckf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [19:0]           elapsed_seconds,
	output logic                  empty,
	input  logic                  pop,
	output logic [15:0]           hour_of_day,
	output logic signed [15:0]    sun_altitude,
	output logic signed [15:0]    sun_azimuth,
	output logic [15:0]           sun_intensity,
	output logic [15:0]           sun_red,
	output logic [15:0]           sun_green,
	output logic [15:0]           sun_blue,
	output logic [15:0]           sky_intensity,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t        cfg_q;
	logic        avail;
	logic        take;
	logic [19:0] head_secs;
	logic        res_valid;
	logic        res_ready;
	result_t     res;
	result_t     head;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_scale <= TIME_SCALE_RST;
			cfg_q.start_hour <= START_HOUR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIME_SCALE: cfg_q.time_scale <= cfg_wdata;
				REG_START_HOUR: cfg_q.start_hour <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dckf_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.elapsed_seconds(elapsed_seconds),
		.take           (take),
		.avail          (avail),
		.head_secs      (head_secs)
	);

	dckf_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.avail    (avail),
		.head_secs(head_secs),
		.take     (take),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	dckf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(res_valid),
		.load_ready(res_ready),
		.load_data (res),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign hour_of_day   = head.hour_of_day;
	assign sun_altitude  = head.sun_altitude;
	assign sun_azimuth   = head.sun_azimuth;
	assign sun_intensity = head.sun_intensity;
	assign sun_red       = head.sun_red;
	assign sun_green     = head.sun_green;
	assign sun_blue      = head.sun_blue;
	assign sky_intensity = head.sky_intensity;

endmodule

// ----- hw/rtl/dckf_checker.sv -----
// ----------------------------------------------------------------------------
// dckf_checker
// Port-level checks on the result side of the keyframe interpolator.
// ----------------------------------------------------------------------------
module dckf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [15:0]        hour_of_day,
	input logic signed [15:0] sun_altitude,
	input logic signed [15:0] sun_azimuth,
	input logic [15:0]        sun_intensity,
	input logic [15:0]        sun_red,
	input logic [15:0]        sun_green,
	input logic [15:0]        sun_blue,
	input logic [15:0]        sky_intensity
);

	// a waiting item holds until it is taken
	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(hour_of_day) && $stable(sun_altitude)
			&& $stable(sun_azimuth) && $stable(sky_intensity))
		else $error("result changed while waiting");

	// hour stays inside one day
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> hour_of_day < 16'd49152)
		else $error("hour of day out of range");

	// interpolated colors never pass 1.0
	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> sun_red <= 16'd32768 && sun_green <= 16'd32768
			&& sun_blue <= 16'd32768)
		else $error("color component above 1.0");

	// intensities stay between the keyframe extremes
	a_intensity_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> sun_intensity <= 16'd9011 && sky_intensity <= 16'd40960)
		else $error("intensity beyond keyframe extremes");

endmodule

bind day_cycle_keyframe_interpolator dckf_checker u_checker (.*);

// ----- dv/tb_day_cycle_keyframe_interpolator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_day_cycle_keyframe_interpolator
// Self-checking bench for the day-cycle keyframe interpolator. A short
// directed plan (reset state, every keyframe hit exactly, out-of-range start
// hour, unmapped register writes, increment extremes) is followed by phases
// of random ticks under changing time scale and start hour. A behavioral
// model of the accumulator and the lighting table predicts every other result,
// the directed keyframe ticks being checked against table rows; both queue sides idle at random.
// ----------------------------------------------------------------------------
module tb_day_cycle_keyframe_interpolator;
	import dckf_pkg::*;

	localparam int       CYCLE_LIMIT   = 400000;
	localparam int       SETTLE_CYCLES = 24;      // block latency plus margin
	localparam int       PHASES        = 14;
	localparam int       PHASE_TICKS   = 118;
	localparam int       KEYS          = 8;
	localparam int       DAY_UNITS     = 49152;   // 24 h in Q5.11
	localparam int       SHORT_SPAN    = 20;      // 0.01 h in Q5.11
	localparam longint   MINUTE_WRAP   = 1440 * 65536;
	localparam logic [19:0] SECS_MAX   = 20'hFFFFF;

	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

	// lighting table: hours, channels, segment reciprocals
	localparam int KEY_HOUR [KEYS] = '{0, 10240, 13312, 16384, 24576, 32768, 37888, 40960};
	localparam int KEY_CHAN [KEYS][7] = '{
		'{-6554,  25723,    0,  3277,  3277,  6554,  4096},
		'{-1638, -19333,  819, 26214, 13107,  6554,  8192},
		'{ 1229, -15401, 4915, 32768, 22938, 13107, 20480},
		'{ 4096, -11715, 7373, 32768, 31130, 27853, 32768},
		'{ 9830,      0, 9011, 32768, 32113, 31130, 40960},
		'{ 4915,  11715, 7782, 32768, 31130, 27853, 32768},
		'{  819,  16712, 4096, 32768, 19661,  9830, 16384},
		'{-2458,  20562,  410,  9830,  6554,  9830,  6554}
	};
	localparam int KEY_RECIP [KEYS] = '{419430, 1398101, 1398101, 524288,
		524288, 838861, 1398101, 524288};

	typedef enum bit {ROW_WRITE, ROW_TICK} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [15:0]           value;
		logic [19:0]           secs;
		logic                  typed;
		result_t               want;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [19:0]           elapsed_seconds;
	logic                  empty;
	logic                  pop;
	logic [15:0]           hour_of_day;
	logic signed [15:0]    sun_altitude;
	logic signed [15:0]    sun_azimuth;
	logic [15:0]           sun_intensity;
	logic [15:0]           sun_red;
	logic [15:0]           sun_green;
	logic [15:0]           sun_blue;
	logic [15:0]           sky_intensity;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// model state and register mirror
	logic [26:0] minutes_acc;
	logic [15:0] scale_cfg;
	logic [15:0] start_cfg;

	result_t pending_light [$];
	row_t    plan [$];
	string   field_name [8];
	bit      quiet;
	int      errors;
	int      ticks_sent;
	int      directed_ticks;
	int      results_seen;
	int      settings_used;
	int      cycle_count;

	day_cycle_keyframe_interpolator uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.elapsed_seconds (elapsed_seconds),
		.empty           (empty),
		.pop             (pop),
		.hour_of_day     (hour_of_day),
		.sun_altitude    (sun_altitude),
		.sun_azimuth     (sun_azimuth),
		.sun_intensity   (sun_intensity),
		.sun_red         (sun_red),
		.sun_green       (sun_green),
		.sun_blue        (sun_blue),
		.sky_intensity   (sky_intensity),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	// clock and watchdog
	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_light.size());
		$display("FAIL day_cycle_keyframe_interpolator");
		$finish;
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 40)
			$display("ERROR %0t: %s", $time, msg);
	endtask

	// advance the minute accumulator by one tick and light the resulting hour
	function automatic result_t step_lighting(input logic [19:0] secs);
		longint      inc;
		longint      total;
		longint      t;
		longint      a;
		longint      b;
		longint      v;
		int          hour;
		int          ia;
		int          ib;
		int          span;
		int          d;
		bit          found;
		logic [15:0] ch [7];
		inc = (longint'(secs) * longint'(scale_cfg)) >>> 8;
		total = (longint'(minutes_acc) + inc) % MINUTE_WRAP;
		minutes_acc = 27'(total);
		hour = int'((longint'(start_cfg) + total / 1920) % DAY_UNITS);
		// segment: first keyframe past the hour, wrapping past midnight
		ia = KEYS - 1;
		ib = 0;
		found = 1'b0;
		for (int i = 0; i < KEYS; i++) begin
			if (!found && KEY_HOUR[i] > hour) begin
				ib = i;
				ia = (i + KEYS - 1) % KEYS;
				found = 1'b1;
			end
		end
		span = KEY_HOUR[ib] - KEY_HOUR[ia];
		if (span <= 0)
			span += DAY_UNITS;
		d = hour - KEY_HOUR[ia];
		if (d < 0)
			d += DAY_UNITS;
		// fraction along the segment, Q0.16, held at zero on very short spans
		t = 0;
		if (span > SHORT_SPAN) begin
			t = (longint'(d) * longint'(KEY_RECIP[ia])) >>> 16;
			if (t > 65536)
				t = 65536;
		end
		for (int c = 0; c < 7; c++) begin
			a = KEY_CHAN[ia][c];
			b = KEY_CHAN[ib][c];
			v = a + (((b - a) * t + 32768) >>> 16);
			ch[c] = 16'(v);
		end
		return {16'(hour), ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], ch[6]};
	endfunction

	// lighting exactly at keyframe i
	function automatic result_t keyframe_light(input int i);
		return {16'(KEY_HOUR[i]), 16'(KEY_CHAN[i][0]), 16'(KEY_CHAN[i][1]),
			16'(KEY_CHAN[i][2]), 16'(KEY_CHAN[i][3]), 16'(KEY_CHAN[i][4]),
			16'(KEY_CHAN[i][5]), 16'(KEY_CHAN[i][6])};
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		plan.push_back('{ROW_WRITE, idx, value, 20'd0, 1'b0, '0});
	endfunction

	function automatic void add_tick(input logic [19:0] secs, input bit typed, input result_t want);
		plan.push_back('{ROW_TICK, '0, 16'd0, secs, typed, want});
	endfunction

	// register write; block must be idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TIME_SCALE)
			scale_cfg = value;
		else if (idx == REG_START_HOUR)
			start_cfg = value;
		@(negedge clk);
	endtask

	// push one tick item; expectation is queued at the accepting edge
	task automatic send_tick(input logic [19:0] secs, input bit typed, input result_t want);
		int      gap;
		result_t model;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		elapsed_seconds <= secs;
		do @(posedge clk); while (full);
		model = step_lighting(secs);
		pending_light.push_back(typed ? want : model);
		ticks_sent++;
		@(negedge clk);
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle();
		push <= 1'b0;
		while (pending_light.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// result side: random pop stalls, field-by-field compare
	initial begin
		int      gap;
		result_t got;
		result_t want;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			got = {hour_of_day, sun_altitude, sun_azimuth, sun_intensity,
				sun_red, sun_green, sun_blue, sky_intensity};
			results_seen++;
			if (pending_light.size() == 0) begin
				flag_error("result with no item waiting for it");
			end else begin
				want = pending_light.pop_front();
				for (int k = 0; k < 8; k++) begin
					if (got[(7-k)*16 +: 16] !== want[(7-k)*16 +: 16])
						flag_error($sformatf("result %0d %s: got 0x%04h, want 0x%04h",
							results_seen, field_name[k], got[(7-k)*16 +: 16],
							want[(7-k)*16 +: 16]));
				end
			end
			@(negedge clk);
		end
	end

	// stimulus
	initial begin
		logic [15:0] ts;
		logic [15:0] sh;
		logic [19:0] secs;
		int          pick;
		field_name = '{"hour_of_day", "sun_altitude", "sun_azimuth", "sun_intensity",
			"sun_red", "sun_green", "sun_blue", "sky_intensity"};
		errors = 0;
		ticks_sent = 0;
		results_seen = 0;
		settings_used = 0;
		cycle_count = 0;
		quiet = 1'b0;
		minutes_acc = '0;
		scale_cfg = TIME_SCALE_RST;
		start_cfg = START_HOUR_RST;
		arst_n <= 1'b0;
		push <= 1'b0;
		elapsed_seconds <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed plan: reset state first, then every keyframe with time frozen
		add_tick(20'd0, 1'b1, keyframe_light(0));
		add_write(REG_TIME_SCALE, 16'd0);
		for (int i = 0; i < KEYS; i++) begin
			add_write(REG_START_HOUR, 16'(KEY_HOUR[i]));
			add_tick(SECS_MAX, 1'b1, keyframe_light(i));
		end
		// start hour past 24 h folds back into the day
		add_write(REG_START_HOUR, 16'(DAY_UNITS + KEY_HOUR[2]));
		add_tick(SECS_MAX, 1'b1, keyframe_light(2));
		// writes to unmapped indexes change nothing
		add_write(REG_UNMAPPED_LO, 16'hFFFF);
		add_write(REG_UNMAPPED_HI, 16'hFFFF);
		add_tick(SECS_MAX, 1'b1, keyframe_light(2));
		// last segment, across midnight
		add_write(REG_START_HOUR, 16'd49151);
		add_tick(20'd0, 1'b0, '0);
		// largest increments wrap the day
		add_write(REG_TIME_SCALE, 16'hFFFF);
		add_tick(SECS_MAX, 1'b0, '0);
		add_tick(SECS_MAX, 1'b0, '0);
		add_tick(20'd1, 1'b0, '0);
		add_write(REG_TIME_SCALE, 16'd256);
		add_write(REG_START_HOUR, 16'd0);
		add_tick(SECS_MAX, 1'b0, '0);
		add_tick(20'd12345, 1'b0, '0);
		add_write(REG_TIME_SCALE, 16'd1);
		add_tick(SECS_MAX, 1'b0, '0);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[i].idx, plan[i].value);
				settings_used++;
			end else begin
				send_tick(plan[i].secs, plan[i].typed, plan[i].want);
			end
		end
		directed_ticks = ticks_sent;

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin ts = 16'd256;   sh = 16'd0;     end
				1: begin ts = 16'hFFFF;  sh = 16'd49151; end
				2: begin ts = 16'd0;     sh = 16'($urandom_range(0, 49151)); end
				3: begin ts = 16'd1;     sh = 16'hFFFF;  end
				default: begin
					ts = 16'($urandom_range(0, 65535));
					sh = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 49151));
				end
			endcase
			quiet = (ph % 4 == 3);
			write_reg(REG_TIME_SCALE, ts);
			write_reg(REG_START_HOUR, sh);
			if (ph % 5 == 2)
				write_reg(($urandom_range(0, 1) == 0) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
					16'($urandom_range(0, 65535)));
			settings_used++;
			for (int n = 0; n < PHASE_TICKS; n++) begin
				// hold the sender until the block has drained once in a while
				if (ph % 3 == 1 && n == PHASE_TICKS / 2)
					settle();
				pick = $urandom_range(0, 9);
				if (pick == 0)
					secs = 20'd0;
				else if (pick == 1)
					secs = SECS_MAX;
				else if (pick <= 4)
					secs = 20'($urandom_range(0, 4095));
				else
					secs = 20'($urandom);
				send_tick(secs, 1'b0, '0);
			end
		end
		quiet = 1'b0;
		settle();

		$display("Ran %0d ticks (%0d directed) across %0d register settings,",
			ticks_sent, directed_ticks, settings_used);
		$display("checked %0d results over all keyframe segments; %0d mismatches.",
			results_seen, errors);
		if (errors == 0)
			$display("PASS day_cycle_keyframe_interpolator");
		else
			$display("FAIL day_cycle_keyframe_interpolator");
		$finish;
	end

endmodule
